>>> sv/srle_pkg.sv
// ---------------------------------------------------------------------------
// srle_pkg
// types, codes and encode functions shared by the scanline rle encoder
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package srle_pkg;

   localparam int MaxRun     = 127;
   localparam int MaxResults = 8;
   localparam int IdxWidth   = 17;
   localparam int WordWidth  = 16;
   localparam int CountWidth = 7;
   localparam int NumWidth   = $clog2(MaxResults + 1);

   // run mode codes, code 3 is unused and acts as no run open
   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_REP  = 2'd1;
   localparam logic [1:0] MODE_LIT  = 2'd2;

   typedef struct packed {
      logic [1:0]            mode;
      logic [CountWidth-1:0] count;
      logic [WordWidth-1:0]  value;
      logic [IdxWidth-1:0]   hslot;
      logic [IdxWidth-1:0]   wpos;
   } rle_state_type;

   typedef struct packed {
      logic [IdxWidth-1:0]  out_index;
      logic [WordWidth-1:0] out_word;
      logic                 row_done;
   } rle_result_type;

   typedef struct packed {
      rle_state_type                         st;
      rle_result_type [MaxResults-1:0]       res;
      logic [NumWidth-1:0]                   num;
   } rle_acc_type;

   // append one result word
   function automatic rle_acc_type srle_put(rle_acc_type a, logic [IdxWidth-1:0] idx,
                                            logic [WordWidth-1:0] w, logic d);
      rle_acc_type r;
      r = a;
      r.res[a.num[$clog2(MaxResults)-1:0]].out_index = idx;
      r.res[a.num[$clog2(MaxResults)-1:0]].out_word  = w;
      r.res[a.num[$clog2(MaxResults)-1:0]].row_done  = d;
      r.num = a.num + NumWidth'(1);
      return r;
   endfunction

   // write the literal header back at its reserved slot
   function automatic rle_acc_type srle_close_lit(rle_acc_type a);
      rle_acc_type r;
      r = srle_put(a, a.st.hslot,
                   {{(WordWidth-CountWidth-1){1'b0}}, 1'b1, a.st.count}, 1'b0);
      r.st.mode  = MODE_NONE;
      r.st.count = '0;
      return r;
   endfunction

   // decide one element with up to two following elements
   function automatic rle_acc_type srle_encode(rle_acc_type a, logic [WordWidth-1:0] x,
                                               logic h1, logic [WordWidth-1:0] x1,
                                               logic h2, logic [WordWidth-1:0] x2);
      rle_acc_type r;
      r = a;
      if (r.st.mode == MODE_LIT && h2 && x == x1 && x == x2) begin
         r = srle_close_lit(r);
      end
      if (r.st.mode != MODE_REP && r.st.mode != MODE_LIT) begin
         if (h1 && x == x1) begin
            r.st.mode  = MODE_REP;
            r.st.value = x;
         end else begin
            r.st.mode  = MODE_LIT;
            r.st.hslot = r.st.wpos;
            r.st.wpos  = r.st.wpos + IdxWidth'(1);
         end
         r.st.count = '0;
      end
      if (r.st.mode == MODE_REP) begin
         r.st.count = r.st.count + CountWidth'(1);
         if (!h1 || x1 != r.st.value || r.st.count >= CountWidth'(MaxRun)) begin
            r = srle_put(r, r.st.wpos, {{(WordWidth-CountWidth){1'b0}}, r.st.count}, 1'b0);
            r = srle_put(r, r.st.wpos + IdxWidth'(1), r.st.value, 1'b0);
            r.st.wpos  = r.st.wpos + IdxWidth'(2);
            r.st.mode  = MODE_NONE;
            r.st.count = '0;
         end
      end else begin
         r = srle_put(r, r.st.wpos, x, 1'b0);
         r.st.wpos  = r.st.wpos + IdxWidth'(1);
         r.st.count = r.st.count + CountWidth'(1);
         if (r.st.count >= CountWidth'(MaxRun)) begin
            r = srle_close_lit(r);
         end
      end
      return r;
   endfunction

endpackage

>>> sv/srle_if.sv
// ---------------------------------------------------------------------------
// srle channel interfaces
// valid/ready channels for requests and result words
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface srle_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] element_value;
   logic        last_in_row;

   modport source (output valid, output element_value, output last_in_row, input ready);
   modport sink   (input valid, input element_value, input last_in_row, output ready);
endinterface

interface srle_rsp_if;
   logic        valid;
   logic        ready;
   logic [16:0] out_index;
   logic [15:0] out_word;
   logic        row_done;

   modport source (output valid, output out_index, output out_word, output row_done,
                   input ready);
   modport sink   (input valid, input out_index, input out_word, input row_done,
                   output ready);
endinterface

>>> sv/scanline_rle_encoder_unit.sv
// ---------------------------------------------------------------------------
// scanline_rle_encoder_unit
// run-length encoder for one 16-bit channel of an image row
// ---------------------------------------------------------------------------
// usage
//   req_chan carries one element per request, last_in_row marks the row end.
//   rsp_chan carries encoded words one at a time, each with its own index in
//   the encoded row; literal headers arrive after their elements.
//   csr_wr_en / csr_wr_data write rle_enable (1 = rle, 0 = verbatim); a write
//   drops any partial row, so write only while the block is idle.
// data flow and throughput
//   a request is held in an input register, then encoded, once the result
//   group is free, into a registered result group of up to eight words;
//   the first word of the group is then valid on rsp_chan.
//   one request per cycle is taken while each request yields at most one
//   word and rsp_chan does not stall; a request yielding more words holds
//   the input while the result group drains on rsp_chan, one word per cycle when ready.
// reset and stall
//   reset selects rle mode and clears all row state and pending words.
//   when rsp_chan stalls, the result group holds and req_chan.ready drops
//   once the input register is also full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scanline_rle_encoder_unit
   import srle_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   srle_req_if.sink       req_chan,
   srle_rsp_if.source     rsp_chan,
   input  logic           csr_wr_en,
   input  logic           csr_wr_data
);

   localparam int PtrWidth = $clog2(MaxResults);

   // input register
   logic                 req_valid_ff, req_valid_in;
   logic [WordWidth-1:0] req_value_ff, req_value_in;
   logic                 req_last_ff,  req_last_in;

   // encoder state
   logic                 en_ff,    en_in;
   rle_state_type        st_ff,    st_in;
   logic [WordWidth-1:0] win_ff [2];
   logic [WordWidth-1:0] win_in [2];
   logic [1:0]           fill_ff,  fill_in;

   // result group
   rle_result_type       res_ff [MaxResults];
   rle_result_type       res_in [MaxResults];
   logic [NumWidth-1:0]  num_ff,   num_in;
   logic [NumWidth-1:0]  ptr_ff,   ptr_in;

   logic [NumWidth-1:0]  remain;
   logic                 rsp_fire;
   logic                 grp_free;
   logic                 process;
   rle_acc_type          acc;
   logic [1:0]           fill_eff;
   logic [1:0]           seq_cnt;
   logic [WordWidth-1:0] seq [3];

   // output side
   assign remain         = num_ff - ptr_ff;
   assign rsp_chan.valid = (remain != '0);
   assign rsp_chan.out_index = res_ff[ptr_ff[PtrWidth-1:0]].out_index;
   assign rsp_chan.out_word  = res_ff[ptr_ff[PtrWidth-1:0]].out_word;
   assign rsp_chan.row_done  = res_ff[ptr_ff[PtrWidth-1:0]].row_done;
   assign rsp_fire       = rsp_chan.valid && rsp_chan.ready;

   // group can take a new request result if it empties this cycle
   assign grp_free = (remain == '0) || (remain == NumWidth'(1) && rsp_fire);
   assign process  = req_valid_ff && grp_free;

   // input register takes a request when empty or being consumed
   assign req_chan.ready = !req_valid_ff || grp_free;

   // window count, code 3 never occurs but is clamped
   assign fill_eff = (fill_ff == 2'd3) ? 2'd2 : fill_ff;
   assign seq_cnt  = fill_eff + 2'd1;

   // row tail: pending window followed by the last element
   always_comb begin
      seq[0] = (fill_eff != 2'd0) ? win_ff[0] : req_value_ff;
      seq[1] = (fill_eff == 2'd0) ? '0 : ((fill_eff == 2'd1) ? req_value_ff : win_ff[1]);
      seq[2] = (fill_eff == 2'd2) ? req_value_ff : '0;
   end

   // encode one request
   always_comb begin
      acc     = '0;
      acc.st  = st_ff;
      win_in  = win_ff;
      fill_in = fill_eff;
      if (!en_ff) begin
         // verbatim pass-through
         acc = srle_put(acc, st_ff.wpos, req_value_ff, req_last_ff);
         acc.st.wpos = st_ff.wpos + IdxWidth'(1);
         if (req_last_ff) begin
            acc.st  = '0;
            fill_in = 2'd0;
         end
      end else if (!req_last_ff) begin
         if (fill_eff < 2'd2) begin
            win_in[fill_eff[0]] = req_value_ff;
            fill_in = fill_eff + 2'd1;
         end else begin
            acc = srle_encode(acc, win_ff[0], 1'b1, win_ff[1], 1'b1, req_value_ff);
            win_in[0] = win_ff[1];
            win_in[1] = req_value_ff;
         end
      end else begin
         // flush the tail of the row, up to three elements
         for (int i = 0; i < 3; i++) begin
            if (2'(i) < seq_cnt) begin
               acc = srle_encode(acc, seq[i],
                                 ((i + 1) < int'(seq_cnt)), (i < 2) ? seq[(i + 1) % 3] : '0,
                                 ((i + 2) < int'(seq_cnt)), (i < 1) ? seq[(i + 2) % 3] : '0);
            end
         end
         if (acc.st.mode == MODE_LIT) begin
            acc = srle_close_lit(acc);
         end
         // zero terminator
         acc = srle_put(acc, acc.st.wpos, '0, 1'b1);
         acc.st  = '0;
         fill_in = 2'd0;
      end
   end

   // next-state selection
   always_comb begin
      req_valid_in = req_valid_ff;
      req_value_in = req_value_ff;
      req_last_in  = req_last_ff;
      en_in        = en_ff;
      st_in        = st_ff;
      res_in       = res_ff;
      num_in       = num_ff;
      ptr_in       = ptr_ff;

      if (rsp_fire) begin
         ptr_in = ptr_ff + NumWidth'(1);
      end
      if (process) begin
         req_valid_in = 1'b0;
         st_in        = acc.st;
         num_in       = acc.num;
         ptr_in       = '0;
         for (int k = 0; k < MaxResults; k++) begin
            res_in[k] = acc.res[k];
         end
      end
      if (req_chan.valid && req_chan.ready) begin
         req_valid_in = 1'b1;
         req_value_in = req_chan.element_value;
         req_last_in  = req_chan.last_in_row;
      end
      // mode write drops the partial row
      if (csr_wr_en) begin
         en_in = csr_wr_data;
         st_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         en_ff        <= 1'b1;
         st_ff        <= '0;
         fill_ff      <= 2'd0;
         num_ff       <= '0;
         ptr_ff       <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         en_ff        <= en_in;
         st_ff        <= st_in;
         fill_ff      <= csr_wr_en ? 2'd0 : (process ? fill_in : fill_ff);
         num_ff       <= num_in;
         ptr_ff       <= ptr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_value_ff <= req_value_in;
      req_last_ff  <= req_last_in;
      res_ff       <= res_in;
      if (process) begin
         win_ff <= win_in;
      end
   end

endmodule

>>> sv/srle_checker.sv
// ---------------------------------------------------------------------------
// srle_checker
// port-level checks for the scanline rle encoder
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module srle_checker (
   input logic        clock,
   input logic        reset,
   input logic        csr_wr_en,
   input logic        csr_wr_data,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [16:0] rsp_out_index,
   input logic [15:0] rsp_out_word,
   input logic        rsp_row_done
);

   // mode as seen on the csr port
   logic en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= 1'b1;
      end else if (csr_wr_en) begin
         en_ff <= csr_wr_data;
      end
   end

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_index)
                                  && $stable(rsp_out_word) && $stable(rsp_row_done))
      else $error("stalled result changed");

   // in rle mode the row ends with a zero terminator
   a_term_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_done && en_ff |-> rsp_out_word == 16'd0)
      else $error("row end word is not zero");

   // a presented word carries no unknown bits
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown({rsp_out_index, rsp_out_word, rsp_row_done}))
      else $error("result word has unknown bits");

endmodule

bind scanline_rle_encoder_unit srle_checker u_srle_checker (
   .clock         (clock),
   .reset         (reset),
   .csr_wr_en     (csr_wr_en),
   .csr_wr_data   (csr_wr_data),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_out_index (rsp_chan.out_index),
   .rsp_out_word  (rsp_chan.out_word),
   .rsp_row_done  (rsp_chan.row_done)
);
